[sv/sdfe_pkg.sv]
`timescale 1ns / 1ps
package sdfe_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_LEN = 2'd1;

	localparam logic [CFG_DATA_W-1:0] PHASE_INC_RESET = 32'd53687091;
	localparam logic [LEN_W-1:0] FADE_LEN_RESET = 16'd240;

	// Envelope full scale and the fixed shift applied after the product.
	localparam int FULL_SCALE = 32767;
	localparam int PROD_SHIFT = 15;

	// Quotient of a 16-bit magnitude times full scale over a 16-bit length.
	localparam int QUOT_W = 31;
	localparam int DIV_STEPS = QUOT_W;
	localparam int ENV_W = QUOT_W + 1;
	localparam int PROD_W = SAMPLE_W + ENV_W;

	localparam int QUEUE_DEPTH = 2;

	// One unit of work handed from the front end to the arithmetic back end.
	typedef struct packed {
		logic                       sounding;
		logic                       sustain;
		logic                       neg;
		logic [LEN_W-1:0]           mag;
		logic [LEN_W-1:0]           len;
		logic signed [SAMPLE_W-1:0] wave;
	} sdfe_job_t;

	// First quarter of the sine wave, entries 0 to 64 inclusive.
	localparam logic [14:0] QUARTER_WAVE [0:64] = '{
		15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
		15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
		15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
		15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
		15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
		15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
		15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
		15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757,
		15'd32767
	};

	// Full 256-entry sine table folded from the quarter wave.
	function automatic logic signed [SAMPLE_W-1:0] sine_rom(input logic [7:0] i);
		logic [7:0] a;
		logic [15:0] m;
		case (i[7:6])
			2'b00: a = {2'b00, i[5:0]};
			2'b01: a = 8'd128 - i;
			2'b10: a = {2'b00, i[5:0]};
			2'b11: a = 8'd0 - i;
			default: a = 8'd0;
		endcase
		m = {1'b0, QUARTER_WAVE[a[6:0]]};
		sine_rom = i[7] ? $signed(16'd0 - m) : $signed(m);
	endfunction

endpackage

[sv/sidetone_dds_with_fade_envelope_unit.sv]
`timescale 1ns / 1ps
// Channel   Handshake           Beat carries
// input     push / full         action, key_pressed
// result    empty / pop         sample, sounding
// config    cfg_write           cfg_index, cfg_data
//
// A beat on the input is taken whenever the queue has room: the front end steps the fade
// machine and the phase accumulator at once and queues the work for the back end.
// The back end takes a silent or restart beat straight to output, a sustained beat
// or a fade with a zero ramp length through the multiply only, and any other beat
// inside a fade through the one-bit-a-cycle divider that forms the envelope first.
// The two-entry queue and the result register let both sides stall on their own;
// full rises only when the queue holds two beats.
// Reset clears the fade machine, the phase, the queue and the result valid flag
// and loads the register defaults; no clearing pass is needed.
module sidetone_dds_with_fade_envelope_unit #(
	parameter int PHASE_BITS = 32,
	parameter int TABLE_INDEX_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [sdfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sdfe_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 push,
	output logic                                 full,
	input  logic                                 action,
	input  logic                                 key_pressed,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [sdfe_pkg::SAMPLE_W-1:0] sample,
	output logic                                 sounding
);

	// The front end only moves when the queue has room for the beat it produces.
	logic                accept;
	sdfe_pkg::sdfe_job_t front_job;
	sdfe_pkg::sdfe_job_t back_job;
	logic                job_valid;
	logic                job_take;
	logic                back_busy;

	assign accept = push && !full;

	sdfe_front #(
		.PHASE_BITS(PHASE_BITS),
		.TABLE_INDEX_BITS(TABLE_INDEX_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.accept(accept),
		.action(action),
		.key_pressed(key_pressed),
		.job(front_job)
	);

	sdfe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(accept),
		.wr_data(front_job),
		.full(full),
		.rd_en(job_take),
		.rd_valid(job_valid),
		.rd_data(back_job)
	);

	// For a fading beat the back end turns the envelope numerator into a gain by serial
	// division; it then scales the table value and clamps it into the result register.
	sdfe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(back_job),
		.job_take(job_take),
		.busy(back_busy),
		.empty(empty),
		.pop(pop),
		.sample(sample),
		.sounding(sounding)
	);

	// A silent result always carries a zero sample.
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !sounding) |-> (sample == '0))
		else $error("silent result with a non-zero sample");

	// The clamp keeps the most negative code off the output.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (sample != -sdfe_pkg::SAMPLE_W'(32768)))
		else $error("sample escaped the clamp");

	// A full queue always has a beat for the back end to take.
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> job_valid)
		else $error("queue full but reports no waiting beat");

	// The back end only takes a beat when it is idle.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> !back_busy)
		else $error("back end took a beat while busy");

endmodule

[sv/sdfe_front.sv]
`timescale 1ns / 1ps
module sdfe_front #(
	parameter int PHASE_BITS = 32,
	parameter int TABLE_INDEX_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [sdfe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sdfe_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  accept,
	input  logic                                  action,
	input  logic                                  key_pressed,
	output sdfe_pkg::sdfe_job_t                   job
);

	localparam logic [1:0] MODE_SILENT  = 2'd0;
	localparam logic [1:0] MODE_IN      = 2'd1;
	localparam logic [1:0] MODE_SUSTAIN = 2'd2;
	localparam logic [1:0] MODE_OUT     = 2'd3;

	logic [PHASE_BITS-1:0]          phase_inc_q;
	logic [sdfe_pkg::LEN_W-1:0]     fade_len_q;
	logic [PHASE_BITS-1:0]          phase_q;
	logic [1:0]                     mode_q;
	logic [sdfe_pkg::LEN_W-1:0]     pos_q;

	logic [1:0]                     mode_d;
	logic [sdfe_pkg::LEN_W-1:0]     pos_d;
	logic [sdfe_pkg::LEN_W-1:0]     mirror;
	logic [sdfe_pkg::LEN_W-1:0]     pos_inc;
	logic                           ramp_done;
	logic                           sounding;
	logic [sdfe_pkg::LEN_W:0]       diff;
	logic [sdfe_pkg::LEN_W:0]       diff_neg;
	logic [7:0]                     rom_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= sdfe_pkg::PHASE_INC_RESET[PHASE_BITS-1:0];
			fade_len_q <= sdfe_pkg::FADE_LEN_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				sdfe_pkg::REG_PHASE_INC: phase_inc_q <= cfg_data[PHASE_BITS-1:0];
				sdfe_pkg::REG_FADE_LEN: fade_len_q <= cfg_data[sdfe_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign mirror = fade_len_q - pos_q;
	assign pos_inc = pos_q + 1'b1;
	assign ramp_done = (pos_q >= fade_len_q);

	always_comb begin
		mode_d = mode_q;
		pos_d = pos_q;
		case (mode_q)
			MODE_SILENT: begin
				if (key_pressed) begin
					mode_d = MODE_IN;
					pos_d = '0;
				end
			end
			MODE_IN: begin
				if (!key_pressed) begin
					mode_d = MODE_OUT;
					pos_d = mirror;
				end else if (ramp_done) begin
					mode_d = MODE_SUSTAIN;
				end else begin
					pos_d = pos_inc;
				end
			end
			MODE_SUSTAIN: begin
				if (!key_pressed) begin
					mode_d = MODE_OUT;
					pos_d = '0;
				end
			end
			default: begin
				if (key_pressed) begin
					mode_d = MODE_IN;
					pos_d = mirror;
				end else if (ramp_done) begin
					mode_d = MODE_SILENT;
					pos_d = '0;
				end else begin
					pos_d = pos_inc;
				end
			end
		endcase
		if (action) begin
			mode_d = MODE_SILENT;
			pos_d = '0;
		end
	end

	assign sounding = (mode_d != MODE_SILENT);

	// The table always sees an 8-bit index, whatever the configured index width.
	generate
		if (TABLE_INDEX_BITS >= 8) begin : g_idx_wide
			assign rom_idx = phase_q[PHASE_BITS-1 -: 8];
		end else begin : g_idx_narrow
			assign rom_idx = {phase_q[PHASE_BITS-1 -: TABLE_INDEX_BITS],
				{(8 - TABLE_INDEX_BITS){1'b0}}};
		end
	endgenerate

	assign diff = {1'b0, fade_len_q} - {1'b0, pos_d};
	assign diff_neg = '0 - diff;

	always_comb begin
		job.sounding = sounding;
		job.sustain = (mode_d == MODE_SUSTAIN);
		job.len = fade_len_q;
		job.wave = sdfe_pkg::sine_rom(rom_idx);
		if (mode_d == MODE_IN) begin
			job.neg = 1'b0;
			job.mag = pos_d;
		end else begin
			job.neg = diff[sdfe_pkg::LEN_W];
			job.mag = diff[sdfe_pkg::LEN_W] ? diff_neg[sdfe_pkg::LEN_W-1:0]
				: diff[sdfe_pkg::LEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			mode_q <= MODE_SILENT;
			pos_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			if (action) begin
				phase_q <= '0;
			end else if (sounding) begin
				phase_q <= phase_q + phase_inc_q;
			end
		end
	end

endmodule

[sv/sdfe_queue.sv]
`timescale 1ns / 1ps
module sdfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  sdfe_pkg::sdfe_job_t wr_data,
	output logic                full,
	input  logic                rd_en,
	output logic                rd_valid,
	output sdfe_pkg::sdfe_job_t rd_data
);

	localparam int PTR_W = $clog2(sdfe_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(sdfe_pkg::QUEUE_DEPTH + 1);

	sdfe_pkg::sdfe_job_t slot_q [sdfe_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (count_q == CNT_W'(sdfe_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = slot_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(sdfe_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(sdfe_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/sdfe_back.sv]
`timescale 1ns / 1ps
module sdfe_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_valid,
	input  sdfe_pkg::sdfe_job_t                  job,
	output logic                                 job_take,
	output logic                                 busy,
	output logic                                 empty,
	input  logic                                 pop,
	output logic signed [sdfe_pkg::SAMPLE_W-1:0] sample,
	output logic                                 sounding
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_ENV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam int CNT_W = $clog2(sdfe_pkg::DIV_STEPS);
	localparam int LW = sdfe_pkg::LEN_W;
	localparam int QW = sdfe_pkg::QUOT_W;
	localparam int EW = sdfe_pkg::ENV_W;
	localparam int PW = sdfe_pkg::PROD_W;
	localparam int SW = PW - sdfe_pkg::PROD_SHIFT;

	logic [2:0]                         state_q;
	logic [CNT_W-1:0]                   cnt_q;
	logic [LW-1:0]                      rem_q;
	logic [QW-1:0]                      dq_q;
	logic [LW-1:0]                      len_q;
	logic                               neg_q;
	logic                               snd_q;
	logic signed [sdfe_pkg::SAMPLE_W-1:0] wave_q;
	logic signed [EW-1:0]               env_q;
	logic signed [PW-1:0]               prod_q;
	logic                               out_valid_q;
	logic signed [sdfe_pkg::SAMPLE_W-1:0] sample_q;
	logic                               sounding_q;

	logic [LW:0]                        part;
	logic [LW+1:0]                      trial;
	logic                               ge;
	logic [QW-1:0]                      dividend;
	logic signed [SW-1:0]               shifted;
	logic signed [sdfe_pkg::SAMPLE_W-1:0] clamped;
	logic                               out_free;

	assign job_take = (state_q == ST_IDLE) && job_valid;
	assign busy = (state_q != ST_IDLE);
	assign empty = !out_valid_q;
	assign sample = sample_q;
	assign sounding = sounding_q;
	assign out_free = !out_valid_q || pop;

	// Magnitude times full scale, formed as a shift and a subtract.
	assign dividend = {job.mag, {sdfe_pkg::PROD_SHIFT{1'b0}}} - QW'(job.mag);

	// One restoring division step per cycle.
	assign part = {rem_q, dq_q[QW-1]};
	assign trial = {1'b0, part} - {2'b00, len_q};
	assign ge = !trial[LW+1];

	assign shifted = prod_q[PW-1:sdfe_pkg::PROD_SHIFT];

	always_comb begin
		if (shifted > SW'(sdfe_pkg::FULL_SCALE)) begin
			clamped = sdfe_pkg::SAMPLE_W'(sdfe_pkg::FULL_SCALE);
		end else if (shifted < -SW'(sdfe_pkg::FULL_SCALE)) begin
			clamped = -sdfe_pkg::SAMPLE_W'(sdfe_pkg::FULL_SCALE);
		end else begin
			clamped = shifted[sdfe_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					wave_q <= job.wave;
					len_q <= job.len;
					neg_q <= job.neg;
					snd_q <= job.sounding;
					rem_q <= '0;
					dq_q <= dividend;
					cnt_q <= '0;
					if (job.sustain) begin
						env_q <= EW'(sdfe_pkg::FULL_SCALE);
					end else begin
						env_q <= '0;
					end
				end
			end
			ST_DIV: begin
				rem_q <= ge ? trial[LW-1:0] : part[LW-1:0];
				dq_q <= {dq_q[QW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_ENV: begin
				env_q <= neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
			end
			ST_MUL: begin
				prod_q <= wave_q * env_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (!job.sounding) begin
							state_q <= ST_FIN;
						end else if (job.sustain || (job.len == '0)) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(sdfe_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_ENV;
					end
				end
				ST_ENV: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			sample_q <= snd_q ? clamped : '0;
			sounding_q <= snd_q;
		end
	end

endmodule
